>>> hdl/mhlc_pkg.sv
// Package for the mail header line classifier.
// Holds the parser state and result types, character codes and name tables.
// No dependencies.
package mhlc_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam logic [15:0] POS_CAP = (MAX_MESSAGE_BYTES - 1 < 65535) ?
                                    16'(MAX_MESSAGE_BYTES - 1) : 16'hFFFF;
  localparam int NUM_NAMES = 5;
  localparam int MAX_RES   = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] KIND_OTHER = 3'd0;

  typedef enum logic [1:0] {
    EV_LINE = 2'd0,
    EV_BODY = 2'd1,
    EV_END  = 2'd2
  } ev_t;

  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd4, 4'd4, 4'd7, 4'd10, 4'd11};
  localparam logic [87:0] NAME_STR [NUM_NAMES] =
    '{"from", "date", "subject", "message-id", "in-reply-to"};

  typedef struct packed {
    logic                 in_body;
    logic                 after_nl;
    logic                 line_open;
    logic [3:0]           name_pos;
    logic [NUM_NAMES-1:0] cand;
    logic                 colon;
    logic [2:0]           pkind;
    logic [15:0]          byte_cnt;
    logic [15:0]          line_start;
  } st_t;

  localparam st_t ST_RESET = '{
    in_body: 1'b0, after_nl: 1'b0, line_open: 1'b0, name_pos: 4'd0,
    cand: '1, colon: 1'b0, pkind: KIND_OTHER, byte_cnt: 16'd0, line_start: 16'd0
  };

  typedef struct packed {
    ev_t         ev;
    logic [2:0]  kind;
    logic [15:0] off;
    logic [15:0] len;
    logic        fin;
  } res_t;

endpackage

>>> hdl/mhlc_step.sv
// Next-state and result logic for one message byte.
// Depends on mhlc_pkg.
module mhlc_step import mhlc_pkg::*; (
  input  st_t        st_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output st_t        st_o,
  output res_t       res_o [MAX_RES],
  output logic [1:0] cnt_o
);

  function automatic logic [15:0] sat_inc(logic [15:0] p);
    return (p < POS_CAP) ? p + 16'd1 : POS_CAP;
  endfunction

  function automatic logic [15:0] span(logic [15:0] f, logic [15:0] t);
    return (t >= f) ? t - f : 16'd0;
  endfunction

  function automatic res_t mk(ev_t ev, logic [2:0] kind, logic [15:0] off,
                              logic [15:0] len);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.off  = off;
    r.len  = len;
    r.fin  = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] name_char(int i, logic [3:0] pos);
    logic [87:0] s;
    logic [3:0]  l;
    logic [6:0]  base;
    s    = NAME_STR[i];
    l    = NAME_LEN[i];
    base = {l - 4'd1 - pos, 3'b000};
    return s[base +: 8];
  endfunction

  function automatic st_t begin_line(st_t s, logic [15:0] pos);
    st_t t;
    t            = s;
    t.line_open  = 1'b1;
    t.line_start = pos;
    t.name_pos   = 4'd0;
    t.cand       = '1;
    t.colon      = 1'b0;
    t.pkind      = KIND_OTHER;
    return t;
  endfunction

  function automatic st_t feed(st_t s, logic [7:0] c);
    st_t        t;
    logic [7:0] lc;
    t  = s;
    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
    if (!s.colon) begin
      if (c == CH_COLON) begin
        t.colon = 1'b1;
        t.pkind = KIND_OTHER;
        for (int i = NUM_NAMES - 1; i >= 0; i--) begin
          if (s.cand[i] && NAME_LEN[i] == s.name_pos) t.pkind = 3'(i + 1);
        end
      end else begin
        for (int i = 0; i < NUM_NAMES; i++) begin
          if (s.name_pos >= NAME_LEN[i] || name_char(i, s.name_pos) != lc)
            t.cand[i] = 1'b0;
        end
        if (s.name_pos != 4'hF) t.name_pos = s.name_pos + 4'd1;
      end
    end
    return t;
  endfunction

  st_t         s;
  res_t        r [MAX_RES];
  logic [1:0]  n;
  logic [15:0] pos;
  logic [15:0] endp;

  always_comb begin
    s    = st_i;
    pos  = st_i.byte_cnt;
    n    = 2'd0;
    endp = 16'd0;
    for (int k = 0; k < MAX_RES; k++) r[k] = '0;

    if (!s.in_body) begin
      if (s.after_nl) begin
        s.after_nl = 1'b0;
        if (data_i == CH_SP || data_i == CH_TAB) begin
          if (!s.colon) s.cand = '0;
        end else begin
          endp = (pos != 16'd0) ? pos - 16'd1 : 16'd0;
          r[n] = mk(EV_LINE, s.pkind, s.line_start, span(s.line_start, endp));
          n = n + 2'd1;
          s.line_open = 1'b0;
          if (data_i == CH_NL) begin
            r[n] = mk(EV_BODY, KIND_OTHER, pos, 16'd0);
            n = n + 2'd1;
            s.in_body = 1'b1;
          end else begin
            s = feed(begin_line(s, pos), data_i);
          end
        end
      end else if (!s.line_open) begin
        if (data_i == CH_NL) begin
          r[n] = mk(EV_BODY, KIND_OTHER, pos, 16'd0);
          n = n + 2'd1;
          s.in_body = 1'b1;
        end else begin
          s = feed(begin_line(s, pos), data_i);
        end
      end else if (data_i == CH_NL) begin
        s.after_nl = 1'b1;
      end else begin
        s = feed(s, data_i);
      end
    end

    if (last_i) begin
      if (!s.in_body && s.line_open) begin
        endp = s.after_nl ? pos : sat_inc(pos);
        r[n] = mk(EV_LINE, s.pkind, s.line_start, span(s.line_start, endp));
        n = n + 2'd1;
      end
      r[n] = mk(EV_END, KIND_OTHER, sat_inc(pos), 16'd0);
      n = n + 2'd1;
      s = ST_RESET;
    end else begin
      s.byte_cnt = sat_inc(pos);
    end

    if (n != 2'd0) r[n - 2'd1].fin = 1'b1;
  end

  assign st_o  = s;
  assign res_o = r;
  assign cnt_o = n;

endmodule

>>> hdl/mail_header_line_classifier.sv
// Mail header line classifier, top level: input register, parser state,
// three-entry result buffer. Depends on mhlc_pkg and mhlc_step.
//
// Takes one message byte per beat and reports each logical header line (with
// folds), the start of the body and the end of the message. While out_tready
// is high, a byte that causes no result or one result is taken every cycle;
// a byte that causes more results (at most three) stalls the input side until
// its last result is left alone in the result buffer, which drains one beat
// per cycle while out_tready is high. A byte passes the input register, then
// its results the result buffer. The body is consumed without results until
// the byte marked by tlast, after which the parser starts a new message.
module mail_header_line_classifier import mhlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] line_offset, [31:16] line_length
  output logic [4:0]  out_tuser,  // [1:0] event_res, [4:2] header_kind
  output logic        out_tlast   // final_result
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  st_t        st_r;
  st_t        st_nxt;
  res_t       ent_r [MAX_RES];
  res_t       res_new [MAX_RES];
  logic [1:0] cnt_r;
  logic [1:0] cnt_new;
  logic       take;
  logic       proc_go;

  mhlc_step u_step (
    .st_i   (st_r),
    .data_i (in_byte_r),
    .last_i (in_last_r),
    .st_o   (st_nxt),
    .res_o  (res_new),
    .cnt_o  (cnt_new)
  );

  assign out_tvalid = (cnt_r != 2'd0);
  assign take       = out_tvalid && out_tready;
  assign proc_go    = in_v_r && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && take));
  assign in_tready  = !in_v_r || proc_go;

  assign out_tdata = {ent_r[0].len, ent_r[0].off};
  assign out_tuser = {ent_r[0].kind, ent_r[0].ev};
  assign out_tlast = ent_r[0].fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= ST_RESET;
      cnt_r  <= 2'd0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (proc_go) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_new;
      end else if (take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (proc_go) begin
      ent_r <= res_new;
    end else if (take) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

`ifndef SYNTHESIS
  a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == EV_END |-> out_tlast)
    else $error("message end beat without final flag");

  a_single_left_final: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> ent_r[0].fin)
    else $error("last buffered result not marked final");

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && in_last_r |=> st_r.byte_cnt == 16'd0 && !st_r.in_body && !st_r.line_open)
    else $error("parser state not cleared after message end");

  a_body_closed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.in_body |-> !st_r.line_open && !st_r.after_nl)
    else $error("header line open inside body");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |-> cnt_r == 2'd0 || take)
    else $error("result buffer overwritten");
`endif

endmodule
